// ===== rtl/ochp_pkg.sv =====
// ochp_pkg: shared constants, codes and helpers of the comment header parser
// depends on nothing; used by the parser core

package ochp_pkg;

    // default width of the vendor and comment length counters
    localparam int LengthBitsDefault = 32;

    // parser sections, also the section tag of each item
    localparam logic [2:0] PH_MAGIC   = 3'd0;
    localparam logic [2:0] PH_VLEN    = 3'd1;
    localparam logic [2:0] PH_VENDOR  = 3'd2;
    localparam logic [2:0] PH_COUNT   = 3'd3;
    localparam logic [2:0] PH_CLEN    = 3'd4;
    localparam logic [2:0] PH_COMMENT = 3'd5;
    localparam logic [2:0] PH_EXTRA   = 3'd6;
    localparam logic [2:0] PH_IGNORE  = 3'd7;

    // packet status codes
    localparam logic [3:0] ST_BUSY        = 4'd0;
    localparam logic [3:0] ST_OK          = 4'd1;
    localparam logic [3:0] ST_CUT_MAGIC   = 4'd2;
    localparam logic [3:0] ST_BAD_MAGIC   = 4'd3;
    localparam logic [3:0] ST_CUT_VLEN    = 4'd4;
    localparam logic [3:0] ST_CUT_VENDOR  = 4'd5;
    localparam logic [3:0] ST_CUT_COUNT   = 4'd6;
    localparam logic [3:0] ST_CUT_CLEN    = 4'd7;
    localparam logic [3:0] ST_CUT_COMMENT = 4'd8;

    // expected signature at the head of the packet
    localparam logic [7:0] MAGIC_TEXT [8] = '{
        8'h4F, 8'h70, 8'h75, 8'h73, 8'h54, 8'h61, 8'h67, 8'h73
    };

    // status given when the packet ends while in a section
    function automatic logic [3:0] end_status(input logic [2:0] ph);
        logic [3:0] st;
        unique case (ph)
            PH_MAGIC:   st = ST_CUT_MAGIC;
            PH_VLEN:    st = ST_CUT_VLEN;
            PH_VENDOR:  st = ST_CUT_VENDOR;
            PH_COUNT:   st = ST_CUT_COUNT;
            PH_CLEN:    st = ST_CUT_CLEN;
            PH_COMMENT: st = ST_CUT_COMMENT;
            PH_EXTRA:   st = ST_OK;
            default:    st = ST_BUSY;
        endcase
        return st;
    endfunction

endpackage

// ===== rtl/ochp_in_if.sv =====
// ochp_in_if: valid/ready channel carrying one packet byte with its marks
// stands alone; used by the parser core on its input side

interface ochp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, data_byte, has_byte, last, input ready);
    modport sink   (input valid, data_byte, has_byte, last, output ready);
endinterface

// ===== rtl/ochp_out_if.sv =====
// ochp_out_if: valid/ready channel carrying one tagged byte with its status
// stands alone; used by the parser core on its output side

interface ochp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_out;
    logic [2:0]  section;
    logic [31:0] comment_number;
    logic        field_end;
    logic [3:0]  status;
    logic        done_res;

    modport source (output valid, byte_out, section, comment_number, field_end,
                    status, done_res, input ready);
    modport sink   (input valid, byte_out, section, comment_number, field_end,
                    status, done_res, output ready);
endinterface

// ===== rtl/opus_comment_header_parser_core.sv =====
// opus_comment_header_parser_core: streaming parser of a comment header packet
// depends on ochp_pkg, ochp_in_if and ochp_out_if
//
// usage
//   i_in carries one item per handshake: a packet byte (has_byte) and an end
//   mark (last). an item with has_byte low and last high ends an empty or
//   truncated packet; with both low it is an idle step that changes nothing.
//   o_out returns exactly one item per input item, in order: the byte, its
//   section tag, the comment index, a field end flag and the packet status.
//   status and done_res are set on the last item of a packet, or on the
//   eighth byte when the signature is wrong; the rest of that packet is then
//   tagged as ignored.
// timing
//   an item is parsed in the cycle after it is registered, and its result is
//   written to the result register once that register is free; one item per
//   cycle is sustained while the receiver takes results, the limit being the
//   single parse stage that updates the section state.
// reset and stall
//   synchronous reset empties both registers and returns the parser to the
//   signature section. when the receiver stalls, the result register holds
//   and the input register still takes one more item before ready drops.

module opus_comment_header_parser_core #(
    parameter int LENGTH_BITS = ochp_pkg::LengthBitsDefault
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ochp_in_if.sink        i_in,
    ochp_out_if.source     o_out
);
    import ochp_pkg::*;

    // largest length kept; longer vendor or comment lengths saturate here
    localparam logic [31:0] LenMax = 32'hFFFF_FFFF >> (32 - LENGTH_BITS);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_has;
    logic       r_in_last;

    // parser state
    logic [2:0]             r_phase,  n_phase;
    logic [2:0]             r_pos,    n_pos;    // byte index in magic or length word
    logic [23:0]            r_acc,    n_acc;    // low bytes of the length word
    logic [LENGTH_BITS-1:0] r_left,   n_left;   // data bytes still to come
    logic [31:0]            r_cleft,  n_cleft;  // comments not yet finished
    logic [31:0]            r_cidx,   n_cidx;   // current comment index
    logic                   r_mism,   n_mism;   // some signature byte differed

    // result register
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic [2:0]  r_out_section;
    logic [31:0] r_out_cnum;
    logic        r_out_fe;
    logic [3:0]  r_out_status;
    logic        r_out_done;

    // parse stage results
    logic        c_fe;
    logic [3:0]  c_status;
    logic        c_done;
    logic [31:0] len_word;
    logic [31:0] len_sat;
    logic [LENGTH_BITS-1:0] len_clamped;
    logic [LENGTH_BITS-1:0] left_dec;
    logic [31:0] cleft_dec;
    logic        mism_now;

    logic advance;

    // an item leaves the input register when the result register is free
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
            r_in_has  <= i_in.has_byte;
            r_in_last <= i_in.last;
        end
    end

    // parse one item against the current section state
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_acc   = r_acc;
        n_left  = r_left;
        n_cleft = r_cleft;
        n_cidx  = r_cidx;
        n_mism  = r_mism;
        c_fe     = 1'b0;
        c_status = ST_BUSY;
        c_done   = 1'b0;

        len_word    = {r_in_byte, r_acc};
        len_sat     = (len_word > LenMax) ? LenMax : len_word;
        len_clamped = len_sat[LENGTH_BITS-1:0];
        left_dec    = r_left - LENGTH_BITS'(r_left != '0);
        cleft_dec   = r_cleft - 32'(r_cleft != '0);
        mism_now    = r_mism || (r_in_byte != MAGIC_TEXT[r_pos]);

        if (r_in_has) begin
            unique case (r_phase)
                PH_MAGIC: begin
                    n_mism = mism_now;
                    n_pos  = r_pos + 3'd1;
                    if (r_pos == 3'd7) begin
                        c_fe  = 1'b1;
                        n_pos = 3'd0;
                        if (mism_now) begin
                            c_status = ST_BAD_MAGIC;
                            c_done   = 1'b1;
                            n_phase  = PH_IGNORE;
                        end else begin
                            n_phase = PH_VLEN;
                        end
                    end
                end
                PH_VLEN, PH_COUNT, PH_CLEN: begin
                    n_pos = r_pos + 3'd1;
                    unique case (r_pos[1:0])
                        2'd0: n_acc[7:0]   = r_in_byte;
                        2'd1: n_acc[15:8]  = r_in_byte;
                        2'd2: n_acc[23:16] = r_in_byte;
                        2'd3: begin
                            // length word complete
                            c_fe  = 1'b1;
                            n_pos = 3'd0;
                            if (r_phase == PH_VLEN) begin
                                if (len_clamped != '0) begin
                                    n_phase = PH_VENDOR;
                                    n_left  = len_clamped;
                                end else begin
                                    n_phase = PH_COUNT;
                                end
                            end else if (r_phase == PH_COUNT) begin
                                n_cleft = len_word;
                                n_cidx  = '0;
                                n_phase = (len_word != '0) ? PH_CLEN : PH_EXTRA;
                            end else if (len_clamped != '0) begin
                                n_phase = PH_COMMENT;
                                n_left  = len_clamped;
                            end else begin
                                // empty comment closes on its length word
                                n_cidx  = r_cidx + 32'd1;
                                n_cleft = cleft_dec;
                                n_phase = (cleft_dec != '0) ? PH_CLEN : PH_EXTRA;
                                n_left  = '0;
                            end
                        end
                        default: ;
                    endcase
                end
                PH_VENDOR, PH_COMMENT: begin
                    n_left = left_dec;
                    if (left_dec == '0) begin
                        c_fe  = 1'b1;
                        n_pos = 3'd0;
                        if (r_phase == PH_VENDOR) begin
                            n_phase = PH_COUNT;
                        end else begin
                            n_cidx  = r_cidx + 32'd1;
                            n_cleft = cleft_dec;
                            n_phase = (cleft_dec != '0) ? PH_CLEN : PH_EXTRA;
                        end
                    end
                end
                PH_EXTRA: begin
                    c_fe = r_in_last;
                end
                default: ;  // ignoring the rest of a bad packet
            endcase
        end

        // end of packet: final status unless the packet already has one, then back to the signature section
        if (r_in_last) begin
            if (!c_done && n_phase != PH_IGNORE) begin
                c_status = end_status(n_phase);
                c_done   = 1'b1;
            end
            n_phase = PH_MAGIC;
            n_pos   = 3'd0;
            n_left  = '0;
            n_cleft = '0;
            n_cidx  = '0;
            n_mism  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC;
            r_pos   <= 3'd0;
            r_left  <= '0;
            r_cleft <= '0;
            r_cidx  <= '0;
            r_mism  <= 1'b0;
        end else if (advance) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_left  <= n_left;
            r_cleft <= n_cleft;
            r_cidx  <= n_cidx;
            r_mism  <= n_mism;
        end
        if (advance) begin
            r_acc <= n_acc;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out_byte    <= r_in_has ? r_in_byte : 8'd0;
            r_out_section <= r_phase;
            r_out_cnum    <= r_cidx;
            r_out_fe      <= c_fe;
            r_out_status  <= c_status;
            r_out_done    <= c_done;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.byte_out       = r_out_byte;
    assign o_out.section        = r_out_section;
    assign o_out.comment_number = r_out_cnum;
    assign o_out.field_end      = r_out_fe;
    assign o_out.status         = r_out_status;
    assign o_out.done_res       = r_out_done;

endmodule
